// File: sv/swfp_pkg.sv
package swfp_pkg;

  localparam int FIFO_DEPTH_DEF = 64;
  localparam int WIN_LEN = 14;   // longest frame
  localparam int TXT_LEN = 16;   // weight text buffer

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DEC0  = 8'h36;   // decimals code for six places
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [1:0] KIND_EIGHT    = 2'd0;
  localparam logic [1:0] KIND_TWELVE   = 2'd1;
  localparam logic [1:0] KIND_FOURTEEN = 2'd2;
  localparam logic [1:0] KIND_NOTICE   = 2'd3;

  localparam logic [2:0] MODE_ZERO      = 3'd0;
  localparam logic [2:0] MODE_PARSE_MAX = 3'd3;

  localparam logic [13:0] IP_MAX = 14'd9999;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_PASS1,
    ST_PREP,
    ST_PASS2,
    ST_EVAL,
    ST_ACC,
    ST_OUT
  } swfp_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// File: sv/swfp_ram.sv
module swfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/scale_weight_frame_parser.sv
// Weighing scale frame parser.
// Input channel (in_valid / in_stall): one received byte per transaction, with
// in_chunk_last marking the last byte of a link chunk. Result channel
// (out_valid / out_stall): at most one result per input byte, carrying the
// frame kind, a weight-valid flag, sign, integer part and hundredths, and on
// a chunk end whether any frame was recognized in that chunk.
// Configuration (cfg_valid / cfg_ready): writes scale_mode; always ready. The
// user must write it only while the block is idle; the block does not enforce it.
// In a parse mode, bytes go into a receive FIFO held in a single-port-write
// RAM. After every byte the head of the FIFO (at most 14 bytes) is read back
// one byte a cycle, matched against the 8, 12 and 14-byte frame shapes, and a
// matched frame is turned into a weight text that is scanned one character a
// cycle. One byte is in work at a time; a finished result sits in the output
// register while the next byte is taken.
// Reset empties the FIFO, clears mode to 0 and clears the chunk flag. A
// stalled result holds; the block then waits before delivering the next one.
module scale_weight_frame_parser
  import swfp_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_chunk_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_kind,
  output logic        out_weight_valid,
  output logic        out_negative,
  output logic [13:0] out_integer_part,
  output logic [6:0]  out_hundredths,
  output logic        out_chunk_had_weight,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_scale_mode
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  swfp_state_t state_r, state_nxt;

  logic [2:0]    mode_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          seen_r, seen_nxt;
  logic          last_r, last_nxt;
  logic [3:0]    rd_idx_r, rd_idx_nxt;

  logic [7:0] win_r [WIN_LEN];
  logic [7:0] win_nxt [WIN_LEN];
  logic [7:0] src_r [TXT_LEN];
  logic [7:0] src_nxt [TXT_LEN];
  logic [7:0] dst_r [TXT_LEN];
  logic [7:0] dst_nxt [TXT_LEN];

  logic [3:0]  pos_r, pos_nxt;
  logic [3:0]  j_r, j_nxt;
  logic        pre_r, pre_nxt;
  logic        skip_r, skip_nxt;
  logic        sgn_r, sgn_nxt;
  logic        f_is_rev_r, f_is_rev_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [3:0]  kend_r, kend_nxt;

  // pending result
  logic [1:0]  kind_r, kind_nxt;
  logic        wvalid_r, wvalid_nxt;
  logic        minus_r, minus_nxt;
  logic [13:0] ip_r, ip_nxt;
  logic [6:0]  hd_r, hd_nxt;
  logic        chw_r, chw_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  o_kind_r;
  logic        o_wvalid_r, o_neg_r, o_chw_r;
  logic [13:0] o_ip_r;
  logic [6:0]  o_hd_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(FIFO_DEPTH)) begin
      s = s - (CW+1)'(FIFO_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  swfp_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- shared conditions ----------------
  logic in_acc, mode_zero, mode_parse, out_free;
  logic [3:0] nread;
  logic rd_done;
  logic ge8, f0, f1, f2, found, drop;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign mode_zero  = (mode_r == MODE_ZERO);
  assign mode_parse = !mode_zero && (mode_r <= MODE_PARSE_MAX);
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_ready  = 1'b1;

  assign nread   = (count_r > CW'(WIN_LEN)) ? 4'(WIN_LEN) : count_r[3:0];
  assign rd_done = (rd_idx_r == nread);

  // frame shape match on the window
  assign ge8   = (count_r >= CW'(8));
  assign f0    = ge8 && (win_r[0] == CH_EQ);
  assign f1    = ge8 && (count_r >= CW'(12)) && (win_r[0] == CH_STX) && (win_r[11] == CH_ETX);
  assign f2    = ge8 && (count_r >= CW'(14)) && (win_r[0] == CH_STX) && (win_r[13] == CH_ETX);
  assign found = f0 || f1 || f2;
  assign drop  = ge8 && !found && (count_r >= CW'(14));

  assign ram_we    = in_acc && mode_parse && (count_r < CW'(FIFO_DEPTH));
  assign ram_waddr = wrap_add(head_r, count_r);
  assign ram_raddr = wrap_add(head_r, CW'(rd_idx_r));

  // ---------------- digits frame text ----------------
  logic [7:0] dig_t [TXT_LEN];
  logic [7:0] dig_d [6];
  logic [7:0] dig_dc;
  logic [2:0] dot;
  logic       dig_sgn;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dig_d[k] = f1 ? win_r[2 + k] : win_r[4 + k];
    end
    dig_dc  = f1 ? win_r[8] : win_r[10];
    dig_sgn = f1 ? (win_r[1] == CH_MINUS) : (win_r[3] == CH_MINUS);
    dot     = 3'(CH_DEC0 - dig_dc);
    for (int p = 0; p < TXT_LEN; p++) begin
      dig_t[p] = CH_NUL;
    end
    if (dig_dc >= 8'h31 && dig_dc <= 8'h35) begin
      for (int p = 0; p < 7; p++) begin
        if (3'(p) < dot) begin
          dig_t[p] = dig_d[(p < 6) ? p : 5];
        end else if (3'(p) == dot) begin
          dig_t[p] = CH_DOT;
        end else begin
          dig_t[p] = dig_d[(p > 0) ? p - 1 : 0];
        end
      end
    end else if (dig_dc == CH_DEC0) begin
      dig_t[0] = CH_ZERO;
      dig_t[1] = CH_DOT;
      for (int p = 0; p < 6; p++) begin
        dig_t[p + 2] = dig_d[p];
      end
    end else begin
      for (int p = 0; p < 6; p++) begin
        dig_t[p] = dig_d[p];
      end
    end
  end

  // ---------------- character scan step ----------------
  logic [7:0] pc;
  logic       pass_end;

  assign pc       = pre_r ? CH_MINUS : src_r[pos_r];
  assign pass_end = (pc == CH_NUL) || (j_r == 4'd15);

  // ---------------- sign, leading zeros, value present ----------------
  logic       p_sgn, p_from, p_go, p_alive, p_hv;
  logic [3:0] p_i;

  always_comb begin
    p_sgn   = f_is_rev_r ? (dst_r[0] == CH_MINUS) : sgn_r;
    p_from  = f_is_rev_r ? p_sgn : 1'b0;
    p_i     = {3'd0, p_from};
    p_go    = 1'b1;
    for (int n = 0; n < 6; n++) begin
      if (4'(n) >= p_i && p_go) begin
        if (dst_r[n] == CH_ZERO && dst_r[n + 1] != CH_DOT) begin
          p_i = 4'(n + 1);
        end else begin
          p_go = 1'b0;
        end
      end
    end
    p_alive = 1'b1;
    p_hv    = 1'b0;
    for (int k = 0; k < TXT_LEN; k++) begin
      if (dst_r[k] == CH_NUL) begin
        p_alive = 1'b0;
      end
      if (p_alive && (k >= int'(p_from)) && dst_r[k] != CH_ZERO && dst_r[k] != CH_DOT) begin
        p_hv = 1'b1;
      end
    end
  end

  // ---------------- text form check ----------------
  logic [3:0] e_len;
  logic       e_alive, e_mid_ok, e_ok;
  logic [7:0] e_dot_c, e_d1, e_d2;
  logic [6:0] e_hd;

  always_comb begin
    e_len   = 4'd0;
    e_alive = 1'b1;
    for (int k = 0; k < TXT_LEN - 1; k++) begin
      if (dst_r[k] == CH_NUL) begin
        e_alive = 1'b0;
      end
      if (e_alive) begin
        e_len = 4'(k + 1);
      end
    end
    e_mid_ok = 1'b1;
    for (int k = 1; k < TXT_LEN; k++) begin
      if (5'(k + 3) < {1'b0, e_len} && !is_digit(dst_r[k])) begin
        e_mid_ok = 1'b0;
      end
    end
    e_dot_c = dst_r[e_len - 4'd3];
    e_d1    = dst_r[e_len - 4'd2];
    e_d2    = dst_r[e_len - 4'd1];
    e_ok    = (e_len >= 4'd4) &&
              (dst_r[0] == CH_PLUS || dst_r[0] == CH_MINUS || is_digit(dst_r[0])) &&
              (e_dot_c == CH_DOT) && is_digit(e_d1) && is_digit(e_d2) && e_mid_ok;
    e_hd    = 7'(e_d1[3:0]) * 7'd10 + 7'(e_d2[3:0]);
  end

  // ---------------- integer accumulate step ----------------
  logic [7:0]  a_c;
  logic [17:0] a_sum;
  logic        acc_done;

  assign a_c      = dst_r[k_r];
  assign a_sum    = 18'(ip_r) * 18'd10 + 18'(a_c[3:0]);
  assign acc_done = (k_r == kend_r);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_zero) begin
            state_nxt = ST_OUT;
          end else if (mode_parse) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (rd_done) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (found) begin
          state_nxt = f0 ? ST_PASS1 : ST_PREP;
        end else if (!drop) begin
          state_nxt = last_r ? ST_OUT : ST_IDLE;
        end
      end
      ST_PASS1: begin
        if (pass_end) state_nxt = ST_PREP;
      end
      ST_PREP:  state_nxt = ST_PASS2;
      ST_PASS2: begin
        if (pass_end) state_nxt = ST_EVAL;
      end
      ST_EVAL:  state_nxt = e_ok ? ST_ACC : ST_OUT;
      ST_ACC: begin
        if (acc_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    seen_nxt     = seen_r;
    last_nxt     = last_r;
    rd_idx_nxt   = rd_idx_r;
    win_nxt      = win_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    pos_nxt      = pos_r;
    j_nxt        = j_r;
    pre_nxt      = pre_r;
    skip_nxt     = skip_r;
    sgn_nxt      = sgn_r;
    f_is_rev_nxt = f_is_rev_r;
    k_nxt        = k_r;
    kend_nxt     = kend_r;
    kind_nxt     = kind_r;
    wvalid_nxt   = wvalid_r;
    minus_nxt    = minus_r;
    ip_nxt       = ip_r;
    hd_nxt       = hd_r;
    chw_nxt      = chw_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          last_nxt   = in_chunk_last;
          rd_idx_nxt = 4'd0;
          if (mode_zero) begin
            kind_nxt   = KIND_NOTICE;
            wvalid_nxt = 1'b1;
            minus_nxt  = 1'b0;
            ip_nxt     = '0;
            hd_nxt     = '0;
            chw_nxt    = 1'b0;
          end
          if (ram_we) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      ST_READ: begin
        if (rd_idx_r != 4'd0) begin
          win_nxt[rd_idx_r - 4'd1] = ram_rdata;
        end
        if (!rd_done) begin
          rd_idx_nxt = rd_idx_r + 4'd1;
        end
      end
      ST_CHECK: begin
        if (found) begin
          f_is_rev_nxt = f0;
          sgn_nxt      = dig_sgn;
          pos_nxt      = 4'd0;
          j_nxt        = 4'd0;
          pre_nxt      = 1'b0;
          skip_nxt     = 1'b0;
          kind_nxt     = f0 ? KIND_EIGHT : (f1 ? KIND_TWELVE : KIND_FOURTEEN);
          chw_nxt      = last_r;
          seen_nxt     = !last_r;
          for (int k = 0; k < TXT_LEN; k++) begin
            src_nxt[k] = CH_NUL;
            dst_nxt[k] = f0 ? CH_NUL : dig_t[k];
          end
          // reversed characters of the eight-byte frame
          for (int k = 0; k < 7; k++) begin
            src_nxt[k] = win_r[7 - k];
          end
          // consume the frame
          if (f0) begin
            head_nxt  = wrap_add(head_r, CW'(8));
            count_nxt = count_r - CW'(8);
          end else if (f1) begin
            head_nxt  = wrap_add(head_r, CW'(12));
            count_nxt = count_r - CW'(12);
          end else begin
            head_nxt  = wrap_add(head_r, CW'(14));
            count_nxt = count_r - CW'(14);
          end
        end else if (drop) begin
          // drop one byte from the head and retry
          head_nxt  = wrap_add(head_r, CW'(1));
          count_nxt = count_r - CW'(1);
          for (int k = 0; k < WIN_LEN - 1; k++) begin
            win_nxt[k] = win_r[k + 1];
          end
        end else if (last_r) begin
          kind_nxt   = KIND_NOTICE;
          wvalid_nxt = 1'b0;
          minus_nxt  = 1'b0;
          ip_nxt     = '0;
          hd_nxt     = '0;
          chw_nxt    = seen_r;
          seen_nxt   = 1'b0;
        end
      end
      ST_PASS1, ST_PASS2: begin
        if (!pass_end) begin
          if (pre_r) begin
            pre_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
          // a removed space lets the next character through unchecked
          if (pc == CH_SPACE && !skip_r) begin
            skip_nxt = 1'b1;
          end else begin
            dst_nxt[j_r] = pc;
            j_nxt        = j_r + 4'd1;
            skip_nxt     = 1'b0;
          end
        end
      end
      ST_PREP: begin
        src_nxt  = dst_r;
        pos_nxt  = p_i;
        pre_nxt  = p_sgn && p_hv;
        j_nxt    = 4'd0;
        skip_nxt = 1'b0;
        for (int k = 0; k < TXT_LEN; k++) begin
          dst_nxt[k] = CH_NUL;
        end
      end
      ST_EVAL: begin
        wvalid_nxt = e_ok;
        minus_nxt  = e_ok && (dst_r[0] == CH_MINUS);
        ip_nxt     = '0;
        hd_nxt     = e_ok ? e_hd : 7'd0;
        k_nxt      = is_digit(dst_r[0]) ? 4'd0 : 4'd1;
        kend_nxt   = e_len - 4'd3;
      end
      ST_ACC: begin
        if (!acc_done) begin
          ip_nxt = (a_sum > 18'(IP_MAX)) ? IP_MAX : a_sum[13:0];
          k_nxt  = k_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- output register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_OUT && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_ZERO;
      head_r      <= '0;
      count_r     <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_scale_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    rd_idx_r   <= rd_idx_nxt;
    win_r      <= win_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    pos_r      <= pos_nxt;
    j_r        <= j_nxt;
    pre_r      <= pre_nxt;
    skip_r     <= skip_nxt;
    sgn_r      <= sgn_nxt;
    f_is_rev_r <= f_is_rev_nxt;
    k_r        <= k_nxt;
    kend_r     <= kend_nxt;
    kind_r     <= kind_nxt;
    wvalid_r   <= wvalid_nxt;
    minus_r    <= minus_nxt;
    ip_r       <= ip_nxt;
    hd_r       <= hd_nxt;
    chw_r      <= chw_nxt;
    // load the result; a negative zero loses its sign
    if (state_r == ST_OUT && out_free) begin
      o_kind_r   <= kind_r;
      o_wvalid_r <= wvalid_r;
      o_neg_r    <= minus_r && (ip_r != 14'd0 || hd_r != 7'd0);
      o_ip_r     <= ip_r;
      o_hd_r     <= hd_r;
      o_chw_r    <= chw_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_kind       = o_kind_r;
  assign out_weight_valid     = o_wvalid_r;
  assign out_negative         = o_neg_r;
  assign out_integer_part     = o_ip_r;
  assign out_hundredths       = o_hd_r;
  assign out_chunk_had_weight = o_chw_r;

endmodule

// File: tb/weight_frame_checker.sv
module weight_frame_checker
  import swfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_chunk_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_frame_kind,
  input  logic        out_weight_valid,
  input  logic        out_negative,
  input  logic [13:0] out_integer_part,
  input  logic [6:0]  out_hundredths,
  input  logic        out_chunk_had_weight,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_scale_mode,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = FIFO_DEPTH_DEF;

  typedef logic [7:0] wtext_t [16];

  typedef struct packed {
    logic [1:0]  kind;
    logic        vld;
    logic        neg;
    logic [13:0] ip;
    logic [6:0]  hd;
    logic        chw;
  } weight_res_t;

  logic [7:0]  rx_mem [DEPTH];
  int          rx_head;
  int          rx_count;
  logic        seen_frame;
  logic [2:0]  mode;
  weight_res_t expected_weights [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [7:0] peek(input int k);
    return rx_mem[(rx_head + k) % DEPTH];
  endfunction

  function automatic int text_length(input wtext_t s);
    int n;
    n = 0;
    while (n < 15 && s[n] != CH_NUL) n++;
    return n;
  endfunction

  // Removing a space pulls the next character into its slot, which is then skipped.
  function automatic wtext_t strip_spaces(input wtext_t s);
    int len;
    len = text_length(s);
    for (int i = 0; i < len; i++) begin
      if (s[i] == CH_SPACE) begin
        len--;
        for (int m = i; m < len; m++) s[m] = s[m + 1];
        s[len] = CH_NUL;
      end
    end
    return s;
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
  endfunction

  function automatic void eval_weight(input wtext_t t, input bit sgn, input int from,
                                      inout weight_res_t r);
    wtext_t s;
    int i, j, len, n;
    bit nonzero;
    int unsigned ipv, hdv;
    for (int k = 0; k < 16; k++) s[k] = CH_NUL;
    j = 0;
    i = from;
    while (i < 6) begin
      if (t[i] != CH_ZERO || t[i + 1] == CH_DOT) break;
      i++;
    end
    nonzero = 0;
    n = text_length(t);
    for (int k = from; k < n; k++)
      if (t[k] != CH_ZERO && t[k] != CH_DOT) nonzero = 1;
    if (sgn && nonzero) begin
      s[j] = CH_MINUS;
      j++;
    end
    while (i < 15 && t[i] != CH_NUL && j < 15) begin
      s[j] = t[i];
      j++;
      i++;
    end
    s = strip_spaces(s);
    len = text_length(s);
    r.vld = 0; r.neg = 0; r.ip = 0; r.hd = 0;
    if (len < 4) return;
    if (s[0] != CH_PLUS && s[0] != CH_MINUS && !is_dig(s[0])) return;
    if (s[len - 3] != CH_DOT || !is_dig(s[len - 2]) || !is_dig(s[len - 1])) return;
    for (int k = 1; k < len - 3; k++)
      if (!is_dig(s[k])) return;
    ipv = 0;
    for (int k = is_dig(s[0]) ? 0 : 1; k < len - 3; k++) begin
      ipv = ipv * 10 + (s[k] - CH_ZERO);
      if (ipv > IP_MAX) ipv = IP_MAX;
    end
    hdv = (s[len - 2] - CH_ZERO) * 10 + (s[len - 1] - CH_ZERO);
    r.vld = 1;
    r.neg = (s[0] == CH_MINUS) && (ipv != 0 || hdv != 0);
    r.ip = ipv[13:0];
    r.hd = hdv[6:0];
  endfunction

  function automatic void eval_digits(input int vo, inout weight_res_t r);
    wtext_t t;
    logic [7:0] d [6];
    int dot;
    for (int k = 0; k < 16; k++) t[k] = CH_NUL;
    for (int k = 0; k < 6; k++) d[k] = peek(vo + 1 + k);
    dot = int'(CH_DEC0) - int'(peek(vo + 7));
    if (dot > 0 && dot < 6) begin
      for (int k = 0; k < dot; k++) t[k] = d[k];
      t[dot] = CH_DOT;
      for (int k = dot; k < 6; k++) t[k + 1] = d[k];
    end else if (dot == 0) begin
      t[0] = CH_ZERO;
      t[1] = CH_DOT;
      for (int k = 0; k < 6; k++) t[2 + k] = d[k];
    end else begin
      for (int k = 0; k < 6; k++) t[k] = d[k];
    end
    eval_weight(t, peek(vo) == CH_MINUS, 0, r);
  endfunction

  function automatic void eval_reversed(inout weight_res_t r);
    wtext_t t;
    bit sgn;
    for (int k = 0; k < 16; k++) t[k] = CH_NUL;
    for (int k = 0; k < 7; k++) t[k] = peek(7 - k);
    t = strip_spaces(t);
    sgn = t[0] == CH_MINUS;
    eval_weight(t, sgn, sgn ? 1 : 0, r);
  endfunction

  // Push one byte, scan the FIFO head and return 1 when a result is due.
  function automatic bit predict_weight(input logic [7:0] b, input logic last,
                                        output weight_res_t r);
    int kind, used;
    r = '0;
    if (mode == MODE_ZERO) begin
      r.kind = KIND_NOTICE;
      r.vld = 1;
      return 1;
    end
    if (mode > MODE_PARSE_MAX) return 0;
    if (rx_count < DEPTH) begin
      rx_mem[(rx_head + rx_count) % DEPTH] = b;
      rx_count++;
    end
    kind = -1;
    used = 0;
    while (rx_count >= 8) begin
      if (peek(0) == CH_EQ) begin
        kind = KIND_EIGHT; used = 8;
      end else if (rx_count >= 12 && peek(0) == CH_STX && peek(11) == CH_ETX) begin
        kind = KIND_TWELVE; used = 12;
      end else if (rx_count >= 14 && peek(0) == CH_STX && peek(13) == CH_ETX) begin
        kind = KIND_FOURTEEN; used = 14;
      end else if (rx_count >= 14) begin
        // no frame shape fits: drop the head byte and rescan
        rx_head = (rx_head + 1) % DEPTH;
        rx_count--;
        continue;
      end
      break;
    end
    if (kind >= 0) begin
      if (kind == KIND_EIGHT) eval_reversed(r);
      else eval_digits(kind == KIND_TWELVE ? 1 : 3, r);
      rx_head = (rx_head + used) % DEPTH;
      rx_count -= used;
      r.kind = kind[1:0];
      r.chw = last;
      seen_frame = !last;
      return 1;
    end
    if (last) begin
      r.kind = KIND_NOTICE;
      r.chw = seen_frame;
      seen_frame = 0;
      return 1;
    end
    return 0;
  endfunction

  task automatic report(input string field, input int unsigned exp_v, input int unsigned act_v);
    fail_count++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    weight_res_t e;
    weight_res_t p;
    if (!rst_n) begin
      rx_head = 0;
      rx_count = 0;
      seen_frame = 0;
      mode = MODE_ZERO;
      expected_weights.delete();
    end else begin
      // check the result first: a byte taken at this edge cannot answer yet
      if (out_valid && !out_stall) begin
        if (expected_weights.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, expected none, got kind %0d", $time,
                   out_frame_kind);
        end else begin
          e = expected_weights.pop_front();
          if (out_frame_kind !== e.kind) report("frame_kind", e.kind, out_frame_kind);
          if (out_weight_valid !== e.vld) report("weight_valid", e.vld, out_weight_valid);
          if (out_negative !== e.neg) report("negative", e.neg, out_negative);
          if (out_integer_part !== e.ip) report("integer_part", e.ip, out_integer_part);
          if (out_hundredths !== e.hd) report("hundredths", e.hd, out_hundredths);
          if (out_chunk_had_weight !== e.chw)
            report("chunk_had_weight", e.chw, out_chunk_had_weight);
        end
      end
      if (cfg_valid && cfg_ready) mode = cfg_scale_mode;
      if (in_valid && !in_stall)
        if (predict_weight(in_rx_byte, in_chunk_last, p)) expected_weights.push_back(p);
    end
    pending = expected_weights.size();
  end

endmodule

// File: tb/tb_top.sv
module tb_top
  import swfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_PARSE_MIN  = 3'd1;
  localparam logic [2:0] MODE_IGNORE_MAX = 3'd7;
  localparam int IDLE_PCT     = 38;
  localparam int SETTLE       = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        in_chunk_last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_frame_kind;
  logic        out_weight_valid;
  logic        out_negative;
  logic [13:0] out_integer_part;
  logic [6:0]  out_hundredths;
  logic        out_chunk_had_weight;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_scale_mode;

  int fail_count;
  int pending;
  int bytes_sent;
  int frames_sent;
  int quiet_cycles;
  bit idle_on;
  bit stall_on;
  bit hold_go;
  int hold_left;

  scale_weight_frame_parser u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .in_chunk_last        (in_chunk_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_kind       (out_frame_kind),
    .out_weight_valid     (out_weight_valid),
    .out_negative         (out_negative),
    .out_integer_part     (out_integer_part),
    .out_hundredths       (out_hundredths),
    .out_chunk_had_weight (out_chunk_had_weight),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_scale_mode       (cfg_scale_mode)
  );

  weight_frame_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .in_chunk_last        (in_chunk_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_kind       (out_frame_kind),
    .out_weight_valid     (out_weight_valid),
    .out_negative         (out_negative),
    .out_integer_part     (out_integer_part),
    .out_hundredths       (out_hundredths),
    .out_chunk_had_weight (out_chunk_had_weight),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_scale_mode       (cfg_scale_mode),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: end the run if no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off counted here so the
  // block backs up and stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_go) begin
        hold_go = 0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= stall_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one byte; hold it steady until the block takes the transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_rx_byte    <= b;
    in_chunk_last <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] fr [$]);
    bit end_chunk;
    end_chunk = $urandom_range(99) < 40;
    for (int k = 0; k < fr.size(); k++)
      send_byte(fr[k], (k == fr.size() - 1) ? end_chunk : ($urandom_range(99) < 3));
    frames_sent++;
  endtask

  // Write the mode only once the block has drained and gone quiet.
  task automatic set_mode(input logic [2:0] m);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_scale_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] any_digit();
    return ($urandom_range(99) < 30) ? CH_ZERO : CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Mostly digits, with the characters that steer the text checks mixed in.
  function automatic logic [7:0] weight_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return any_digit();
    if (r < 72) return CH_SPACE;
    if (r < 80) return CH_DOT;
    if (r < 86) return CH_MINUS;
    if (r < 90) return CH_PLUS;
    if (r < 93) return CH_NUL;
    return 8'($urandom_range(255));
  endfunction

  task automatic eight_frame();
    logic [7:0] t [7];
    logic [7:0] fr [$];
    int r;
    r = $urandom_range(99);
    t[0] = (r < 30) ? CH_MINUS : (r < 45) ? CH_SPACE : any_digit();
    for (int k = 1; k < 4; k++) t[k] = any_digit();
    t[4] = CH_DOT;
    t[5] = any_digit();
    t[6] = any_digit();
    if ($urandom_range(99) < 30) t[$urandom_range(6)] = weight_char();
    fr.push_back(CH_EQ);
    for (int k = 6; k >= 0; k--) fr.push_back(t[k]);
    send_frame(fr);
  endtask

  task automatic digits_frame(input bit fourteen);
    logic [7:0] fr [$];
    int r;
    fr.push_back(CH_STX);
    if (fourteen) begin
      fr.push_back(8'($urandom_range(255)));
      fr.push_back(8'($urandom_range(255)));
    end
    r = $urandom_range(99);
    fr.push_back((r < 35) ? CH_MINUS : (r < 55) ? CH_PLUS : (r < 75) ? CH_SPACE :
                 weight_char());
    for (int k = 0; k < 6; k++)
      fr.push_back(($urandom_range(99) < 80) ? any_digit() : weight_char());
    // decimals code: mostly 0..6 places, sometimes anything
    fr.push_back(($urandom_range(99) < 80) ? CH_DEC0 - 8'($urandom_range(6)) :
                 8'($urandom_range(255)));
    fr.push_back(8'($urandom_range(255)));
    fr.push_back(8'($urandom_range(255)));
    fr.push_back(CH_ETX);
    send_frame(fr);
  endtask

  task automatic random_bytes(input int n);
    repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(99) < 8);
  endtask

  // Mostly well-formed frames with random content, the rest noise.
  task automatic random_phase(input int n);
    int target;
    int r;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      if (r < 32) eight_frame();
      else if (r < 56) digits_frame(1'b0);
      else if (r < 80) digits_frame(1'b1);
      else random_bytes($urandom_range(1, 5));
    end
  endtask

  initial begin
    logic [7:0] fr [$];
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = 8'h00;
    in_chunk_last  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_scale_mode = MODE_ZERO;
    idle_on        = 1;
    stall_on       = 1;
    hold_go        = 0;
    hold_left      = 0;
    bytes_sent     = 0;
    frames_sent    = 0;
    quiet_cycles   = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero mode straight from reset, with byte extremes.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Ignoring mode: nothing comes back, nothing enters the FIFO.
    set_mode(MODE_IGNORE_MAX);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    set_mode(MODE_PARSE_MIN);
    // Eight-byte frame holding "12  .05": only the first of two spaces goes.
    fr = {CH_EQ, CH_ZERO + 8'd5, CH_ZERO, CH_DOT, CH_SPACE, CH_SPACE,
          CH_ZERO + 8'd2, CH_ZERO + 8'd1};
    send_frame(fr);
    // Twelve-byte negative zero, four decimals, closing the chunk.
    fr = {CH_STX, CH_MINUS, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO,
          CH_DEC0 - 8'd2, 8'h00, 8'hFF, CH_ETX};
    for (int k = 0; k < fr.size(); k++) send_byte(fr[k], k == fr.size() - 1);
    // Chunk end with no frame in the chunk.
    send_byte(8'h41, 1'b1);

    random_phase(400);

    // Zero mode under a long receiver hold-off: the block must back up.
    set_mode(MODE_ZERO);
    hold_go = 1;
    random_bytes(80);

    // Stretch with no idling on either side.
    set_mode(MODE_PARSE_MAX);
    idle_on  = 0;
    stall_on = 0;
    random_phase(250);
    idle_on  = 1;
    stall_on = 1;

    set_mode(3'd5);
    random_bytes(40);

    set_mode(3'd2);
    random_phase(480);

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("sent %0d bytes (%0d frames) across zero, parse and ignore modes",
             bytes_sent, frames_sent);
    $display("including a long result hold-off and a stretch with no idling");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/swfp_pkg.sv
sv/swfp_ram.sv
sv/scale_weight_frame_parser.sv
tb/weight_frame_checker.sv
tb/tb_top.sv
